/* rtl/dabd_pkg.sv */
// shared types, constants and action codes for the detection argmax / box decode block
// no dependencies; imported by every module of the block
package dabd_pkg;

    localparam int NUM_CLASSES = 80;
    localparam int CLASS_W     = 7;
    localparam int SCORE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int NET_W       = 12;
    localparam int CNT_W       = $clog2(NUM_CLASSES + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int DATA_W      = 88;
    localparam int USER_W      = 2;
    localparam int ADDR_W      = 3;
    localparam int APB_W       = 32;

    localparam logic [NET_W-1:0] NET_RESET = NET_W'(640);

    localparam logic [USER_W-1:0] ACT_SCORE = 2'd0;
    localparam logic [USER_W-1:0] ACT_BOX   = 2'd1;
    localparam logic [USER_W-1:0] ACT_LOAD  = 2'd2;

    localparam logic REG_NET_WIDTH  = 1'b0;
    localparam logic REG_NET_HEIGHT = 1'b1;

    typedef struct packed {
        logic [USER_W-1:0]  action;
        logic [SCORE_W-1:0] score;
        logic [CLASS_W-1:0] class_index;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] raw_width;
        logic [COORD_W-1:0] raw_height;
    } dabd_item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic [SCORE_W-1:0] confidence;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] raw_width;
        logic [COORD_W-1:0] raw_height;
    } dabd_job_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic [SCORE_W-1:0] confidence;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
    } dabd_result_t;

    typedef struct packed {
        logic [NET_W-1:0] net_width;
        logic [NET_W-1:0] net_height;
    } dabd_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dabd_fifo_status_t;

endpackage

/* rtl/detection_argmax_box_decode.sv */
// top level of the detection argmax / box decode block: stream ports, apb registers
// depends on dabd_pkg, dabd_front, dabd_fifo and dabd_back
//
// channel   | dir | handshake              | payload
// ----------+-----+------------------------+-------------------------------------------
// s_axis    | in  | s_tvalid / s_tready    | s_tuser action, s_tdata score..raw_height
// m_axis    | out | m_tvalid / m_tready    | m_tdata class_id..box_height
// apb       | in  | psel, penable, pready  | paddr, pwdata, prdata (net_width, net_height)
//
// one item per cycle while s_tready is high; a passing box is queued, then registered
// s_tready drops only when the four-entry job queue is full, i.e. after m_tready stalls
// the threshold table (80 entries) reads zero after reset through per-entry valid bits
// reset leaves argmax cleared, queue empty, net size 640 x 640
module detection_argmax_box_decode
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // score[15:0], class_index[22:16], center_x[38:23], center_y[54:39],
    // raw_width[70:55], raw_height[86:71], zero pad[87]
    input  logic [dabd_pkg::DATA_W-1:0]     s_tdata,
    // action[1:0]
    input  logic [dabd_pkg::USER_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // class_id[6:0], confidence[22:7], left[38:23], top[54:39],
    // box_width[70:55], box_height[86:71], zero pad[87]
    output logic [dabd_pkg::DATA_W-1:0]     m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dabd_pkg::ADDR_W-1:0]     paddr,
    input  logic [dabd_pkg::APB_W-1:0]      pwdata,
    output logic [dabd_pkg::APB_W-1:0]      prdata,
    output logic                            pready
);
    import dabd_pkg::*;

    dabd_cfg_t         cfg_reg, cfg_next;
    dabd_item_t        item;
    dabd_job_t         push_job;
    dabd_job_t         pop_job;
    dabd_fifo_status_t fifo_status;
    dabd_result_t      result;
    logic              push;
    logic              pop;
    logic              cfg_wr;

    assign item.action      = s_tuser;
    assign item.score       = s_tdata[15:0];
    assign item.class_index = s_tdata[22:16];
    assign item.center_x    = s_tdata[38:23];
    assign item.center_y    = s_tdata[54:39];
    assign item.raw_width   = s_tdata[70:55];
    assign item.raw_height  = s_tdata[86:71];

    assign m_tdata = {1'b0, result.box_height, result.box_width, result.top, result.left,
                      result.confidence, result.class_id};

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_NET_WIDTH:  cfg_next.net_width  = pwdata[NET_W-1:0];
                REG_NET_HEIGHT: cfg_next.net_height = pwdata[NET_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_NET_WIDTH:  prdata = APB_W'(cfg_reg.net_width);
            REG_NET_HEIGHT: prdata = APB_W'(cfg_reg.net_height);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.net_width  <= NET_RESET;
            cfg_reg.net_height <= NET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dabd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .item        (item),
        .fifo_status (fifo_status),
        .push        (push),
        .push_job    (push_job)
    );

    dabd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (fifo_status)
    );

    dabd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job         (pop_job),
        .fifo_status (fifo_status),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result      (result)
    );

`ifndef SYNTH
    // a job is only offered to a queue that has room
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !fifo_status.full)
        else $error("job pushed into a full queue");

    // a result always carries a nonzero best score
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> (result.confidence != '0))
        else $error("result with zero confidence");

    // reported class stays within the class count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.class_id < CLASS_W'(NUM_CLASSES)))
        else $error("result class out of range");

    // a queued job moves to the output in the next cycle when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (!fifo_status.empty && !m_tvalid) |=> m_tvalid)
        else $error("queued job not delivered to a free output");
`endif

endmodule

/* rtl/dabd_front.sv */
// front end: accepts items, keeps the running argmax and the per-class threshold table
// depends on dabd_pkg; pushes passing anchors into dabd_fifo
module dabd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dabd_pkg::dabd_item_t          item,
    input  dabd_pkg::dabd_fifo_status_t   fifo_status,
    output logic                          push,
    output dabd_pkg::dabd_job_t           push_job
);
    import dabd_pkg::*;

    logic [SCORE_W-1:0]     best_score_reg, best_score_next;
    logic [CLASS_W-1:0]     best_class_reg, best_class_next;
    logic                   have_best_reg, have_best_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic [SCORE_W-1:0]     thr_mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] thr_valid_reg;
    logic [SCORE_W-1:0]     thr_rd_reg;
    logic                   thr_hit_reg;
    logic                   wr_en;
    logic                   accept;
    logic [SCORE_W-1:0]     threshold;

    assign in_ready  = !fifo_status.full;
    assign accept    = in_valid && in_ready;
    // entries never loaded read as zero
    assign threshold = thr_hit_reg ? thr_rd_reg : '0;

    always_comb
    begin
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        have_best_next  = have_best_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        push            = 1'b0;
        push_job.class_id   = best_class_reg;
        push_job.confidence = best_score_reg;
        push_job.center_x   = item.center_x;
        push_job.center_y   = item.center_y;
        push_job.raw_width  = item.raw_width;
        push_job.raw_height = item.raw_height;
        if (accept)
        begin
            case (item.action)
                ACT_SCORE:
                begin
                    if (count_reg < CNT_W'(NUM_CLASSES))
                    begin
                        if (item.score > best_score_reg)
                        begin
                            best_score_next = item.score;
                            best_class_next = CLASS_W'(count_reg);
                            have_best_next  = 1'b1;
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_BOX:
                begin
                    push            = have_best_reg && (best_score_reg >= threshold);
                    best_score_next = '0;
                    best_class_next = '0;
                    have_best_next  = 1'b0;
                    count_next      = '0;
                end
                ACT_LOAD:
                begin
                    wr_en = (item.class_index < CLASS_W'(NUM_CLASSES));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_class_reg <= '0;
            have_best_reg  <= 1'b0;
            count_reg      <= '0;
            thr_valid_reg  <= '0;
            thr_hit_reg    <= 1'b0;
        end
        else
        begin
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            have_best_reg  <= have_best_next;
            count_reg      <= count_next;
            if (wr_en)
            begin
                thr_valid_reg[item.class_index] <= 1'b1;
            end
            // read ahead at the class the argmax will hold next cycle, write-through on a hit
            thr_hit_reg <= (wr_en && (item.class_index == best_class_next))
                        || thr_valid_reg[best_class_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            thr_mem[item.class_index] <= item.score;
        end
        if (wr_en && (item.class_index == best_class_next))
        begin
            thr_rd_reg <= item.score;
        end
        else
        begin
            thr_rd_reg <= thr_mem[best_class_next];
        end
    end

endmodule

/* rtl/dabd_fifo.sv */
// short job queue between the argmax front end and the box back end
// depends on dabd_pkg for the job type and depth
module dabd_fifo
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  dabd_pkg::dabd_job_t           push_job,
    input  logic                          pop,
    output dabd_pkg::dabd_job_t           pop_job,
    output dabd_pkg::dabd_fifo_status_t   status
);
    import dabd_pkg::*;

    dabd_job_t          slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + FIFO_AW'(1) : wptr_reg;
        rptr_next  = do_pop  ? rptr_reg + FIFO_AW'(1) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/dabd_back.sv */
// back end: turns a queued anchor into a clamped box and holds it in the output register
// depends on dabd_pkg; pops from dabd_fifo
module dabd_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dabd_pkg::dabd_cfg_t           cfg,
    input  dabd_pkg::dabd_job_t           job,
    input  dabd_pkg::dabd_fifo_status_t   fifo_status,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dabd_pkg::dabd_result_t        result
);
    import dabd_pkg::*;

    localparam int EW = COORD_W + 1;

    logic         out_valid_reg, out_valid_next;
    dabd_result_t result_reg, result_next;

    // edges in Q12.5: 2*center -/+ size, near edge floored at 0, far edge clamped to the limit
    function automatic logic [2*COORD_W-1:0] axis_calc(
        input logic [COORD_W-1:0] c,
        input logic [COORD_W-1:0] s,
        input logic [NET_W-1:0]   limit
    );
        logic [EW-1:0] c2;
        logic [EW-1:0] lo;
        logic [EW:0]   hi;
        logic [EW-1:0] lim;
        logic [EW-1:0] hi_c;
        logic [EW-1:0] ext;
        c2   = {c, 1'b0};
        lim  = {limit, 5'b0};
        lo   = (c2 > EW'(s)) ? c2 - EW'(s) : '0;
        hi   = {1'b0, c2} + (EW+1)'(s);
        hi_c = (hi > {1'b0, lim}) ? lim : hi[EW-1:0];
        ext  = (hi_c > lo) ? hi_c - lo : '0;
        return {lo[EW-1:1], ext[EW-1:1]};
    endfunction

    assign pop       = !fifo_status.empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next         = 1'b1;
            result_next.class_id   = job.class_id;
            result_next.confidence = job.confidence;
            {result_next.left, result_next.box_width} =
                axis_calc(job.center_x, job.raw_width, cfg.net_width);
            {result_next.top, result_next.box_height} =
                axis_calc(job.center_y, job.raw_height, cfg.net_height);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench for detection_argmax_box_decode: directed anchors, surplus scores and random
// traffic under several net sizes and idling phases; depends on dabd_pkg and the rtl top
module testbench;
    import dabd_pkg::*;

    localparam logic [USER_W-1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    // score[15:0], class_index[22:16], center_x[38:23], center_y[54:39],
    // raw_width[70:55], raw_height[86:71], zero pad[87]
    logic [DATA_W-1:0] s_tdata;
    // action[1:0]
    logic [USER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    // class_id[6:0], confidence[22:7], left[38:23], top[54:39],
    // box_width[70:55], box_height[86:71], zero pad[87]
    logic [DATA_W-1:0] m_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0] pwdata;
    logic [APB_W-1:0] prdata;
    logic pready;

    // predictor state
    logic [NET_W-1:0]   cfg_net_width;
    logic [NET_W-1:0]   cfg_net_height;
    logic [SCORE_W-1:0] best_score;
    logic [CLASS_W-1:0] best_class;
    logic               have_best;
    int                 anchor_count;
    logic [SCORE_W-1:0] class_thresh [NUM_CLASSES];
    dabd_result_t       pending_detections [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    detection_argmax_box_decode uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("detection_argmax_box_decode test failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] halve_sat(input int v);
        int h;
        h = v >>> 1;
        if (h < 0) h = 0;
        if (h > 65535) h = 65535;
        return h[15:0];
    endfunction

    // edges in q12.5 so the half-size term stays exact, then back to q12.4
    function automatic void decode_axis(input logic [15:0] ctr, input logic [15:0] size,
                                        input logic [NET_W-1:0] limit,
                                        output logic [15:0] near_side,
                                        output logic [15:0] span);
        int lo;
        int hi;
        int lim;
        int ext;
        lo = 2 * int'(ctr) - int'(size);
        hi = 2 * int'(ctr) + int'(size);
        lim = int'(limit) * 32;
        if (lo < 0) lo = 0;
        if (hi > lim) hi = lim;
        ext = hi - lo;
        if (ext < 0) ext = 0;
        near_side = halve_sat(lo);
        span = halve_sat(ext);
    endfunction

    function automatic void clear_anchor();
        best_score = '0;
        best_class = '0;
        have_best = 1'b0;
        anchor_count = 0;
    endfunction

    function automatic void predict_detection(input dabd_item_t it);
        dabd_result_t det;
        if (it.action == ACT_SCORE)
        begin
            if (anchor_count < NUM_CLASSES)
            begin
                if (it.score > best_score)
                begin
                    best_score = it.score;
                    best_class = CLASS_W'(anchor_count);
                    have_best = 1'b1;
                end
                anchor_count++;
            end
        end
        else if (it.action == ACT_LOAD)
        begin
            if (it.class_index < NUM_CLASSES)
                class_thresh[it.class_index] = it.score;
        end
        else if (it.action == ACT_BOX)
        begin
            if (have_best && best_score >= class_thresh[best_class])
            begin
                det.class_id = best_class;
                det.confidence = best_score;
                decode_axis(it.center_x, it.raw_width, cfg_net_width, det.left, det.box_width);
                decode_axis(it.center_y, it.raw_height, cfg_net_height, det.top,
                            det.box_height);
                pending_detections = {pending_detections, det};
            end
            clear_anchor();
        end
    endfunction

    function automatic void report_field(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_detections
        dabd_result_t got;
        dabd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.class_id   = m_tdata[6:0];
            got.confidence = m_tdata[22:7];
            got.left       = m_tdata[38:23];
            got.top        = m_tdata[54:39];
            got.box_width  = m_tdata[70:55];
            got.box_height = m_tdata[86:71];
            if (pending_detections.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected detection, expected none, actual %h", $time, got);
            end
            else
            begin
                want = pending_detections.pop_front();
                report_field("class_id", want.class_id, got.class_id);
                report_field("confidence", want.confidence, got.confidence);
                report_field("left", want.left, got.left);
                report_field("top", want.top, got.top);
                report_field("box_width", want.box_width, got.box_width);
                report_field("box_height", want.box_height, got.box_height);
            end
        end
    end

    // called at a falling edge, returns at a falling edge; tvalid stays up between items unless an idle is drawn
    task automatic send_item(input logic [1:0] act, input logic [15:0] val,
                             input logic [6:0] cls, input logic [15:0] cx, input logic [15:0] cy,
                             input logic [15:0] w, input logic [15:0] h);
        dabd_item_t it;
        it = '{action: act, score: val, class_index: cls, center_x: cx, center_y: cy,
               raw_width: w, raw_height: h};
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = {1'b0, h, w, cy, cx, cls, val};
        do @(posedge clk); while (!s_tready);
        predict_detection(it);
        @(negedge clk);
    endtask

    task automatic send_score(input logic [15:0] val);
        send_item(ACT_SCORE, val, 7'($urandom), rnd16(), rnd16(), rnd16(), rnd16());
    endtask

    task automatic send_box(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] w, input logic [15:0] h);
        send_item(ACT_BOX, rnd16(), 7'($urandom), cx, cy, w, h);
    endtask

    task automatic send_load(input logic [6:0] cls, input logic [15:0] val);
        send_item(ACT_LOAD, val, cls, rnd16(), rnd16(), rnd16(), rnd16());
    endtask

    // block idle: nothing pending and the pipeline given time to empty
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_detections.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_net_reg(input logic reg_idx, input logic [NET_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = {20'($urandom), value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (reg_idx == REG_NET_WIDTH)
            cfg_net_width = value;
        else
            cfg_net_height = value;
        @(negedge clk);
        // read back
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        report_field("register readback", value, prdata[NET_W-1:0]);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_net_size(input logic [NET_W-1:0] w, input logic [NET_W-1:0] h);
        wait_idle();
        write_net_reg(REG_NET_WIDTH, w);
        write_net_reg(REG_NET_HEIGHT, h);
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // box with no scores at all
        send_item(ACT_BOX, 16'hFFFF, 7'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // all-zero anchor has no best class
        send_score(16'h0000);
        send_score(16'h0000);
        send_box(16'h1400, 16'h1400, 16'h0640, 16'h0320);
        // ties keep the first class
        send_score(16'h0000);
        send_score(16'hFFFF);
        send_score(16'hFFFF);
        send_box(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_load(7'd2, 16'h8000);
        send_load(7'd127, 16'hFFFF);
        send_item(ACT_UNUSED, 16'hFFFF, 7'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // best below its threshold
        send_score(16'h0010);
        send_score(16'h0020);
        send_score(16'h7FFF);
        send_box(16'h1400, 16'h1400, 16'h0640, 16'h0320);
        // load in the middle of an anchor, score equal to threshold
        send_score(16'h0000);
        send_score(16'h0000);
        send_load(7'd79, 16'h0001);
        send_score(16'h8000);
        send_box(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        // box past the right and bottom clamp
        send_score(16'h0001);
        send_box(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0010);
    endtask

    task automatic test_surplus_scores();
        for (int i = 0; i < NUM_CLASSES + 4; i++)
        begin
            if (i >= NUM_CLASSES)
                send_score(16'hFFFF);
            else if (i == NUM_CLASSES - 1)
                send_score(16'd2000);
            else
                send_score(16'($urandom_range(0, 1000)));
        end
        send_box(16'h0A00, 16'h0A00, 16'h0400, 16'h0400);
    endtask

    task automatic send_random_score(input int idx);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            send_score(16'h0000);
        else if (pick < 15)
            send_score(16'hFFFF);
        else if (pick < 25 && idx < NUM_CLASSES)
            send_score(class_thresh[idx]);
        else
            send_score(rnd16());
    endtask

    task automatic send_random_box();
        int pick;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            cx = rnd16();
            cy = rnd16();
            w = rnd16();
            h = rnd16();
        end
        else if (pick < 75)
        begin
            cx = 16'($urandom_range(0, int'(cfg_net_width) * 16));
            cy = 16'($urandom_range(0, int'(cfg_net_height) * 16));
            w = 16'($urandom_range(0, 8192));
            h = 16'($urandom_range(0, 8192));
        end
        else
        begin
            cx = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            cy = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            w = ($urandom_range(0, 2) == 0) ? rnd16() : 16'hFFFF;
            h = ($urandom_range(0, 2) == 0) ? 16'h0000 : rnd16();
        end
        send_box(cx, cy, w, h);
    endtask

    task automatic send_noise();
        int pick;
        logic [15:0] val;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            send_item(ACT_UNUSED, rnd16(), 7'($urandom), rnd16(), rnd16(), rnd16(), rnd16());
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                val = 16'($urandom_range(0, 16'h3000));
            else if (pick < 80)
                val = rnd16();
            else if (pick < 90)
                val = 16'h0000;
            else
                val = 16'hFFFF;
            if ($urandom_range(0, 99) < 85)
                send_load(7'($urandom_range(0, NUM_CLASSES - 1)), val);
            else
                send_load(7'($urandom_range(NUM_CLASSES, 127)), val);
        end
    endtask

    // mostly well-formed anchors with random content, plus loads, unused actions and
    // bare boxes mixed in
    task automatic test_random_traffic(input logic [NET_W-1:0] w, input logic [NET_W-1:0] h,
                                       input int idle_pct, input int stall_pct,
                                       input int item_goal);
        int sent;
        int n_scores;
        int pick;
        set_net_size(w, h);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                n_scores = $urandom_range(NUM_CLASSES - 2, NUM_CLASSES + 4);
            else if (pick < 8)
                n_scores = 0;
            else
                n_scores = $urandom_range(1, 6);
            for (int i = 0; i < n_scores; i++)
            begin
                if ($urandom_range(0, 99) < 10)
                begin
                    send_noise();
                    sent++;
                end
                send_random_score(i);
                sent++;
            end
            send_random_box();
            sent++;
        end
        s_tvalid = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_net_width = NET_RESET;
        cfg_net_height = NET_RESET;
        clear_anchor();
        for (int i = 0; i < NUM_CLASSES; i++)
            class_thresh[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_surplus_scores();
        test_random_traffic(12'd4095, 12'd4095, 0, 0, 105);
        test_random_traffic(12'd0, 12'd1, 63, 0, 105);
        test_random_traffic(12'd1, 12'd0, 0, 63, 105);
        test_random_traffic(12'($urandom), 12'($urandom), 29, 29, 105);
        test_random_traffic(12'($urandom_range(1, 1000)), 12'd4095, 0, 0, 105);

        wait_idle();
        if (mismatch_count == 0)
            $display("detection_argmax_box_decode test passed");
        else
            $display("detection_argmax_box_decode test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/dabd_pkg.sv
rtl/dabd_front.sv
rtl/dabd_fifo.sv
rtl/dabd_back.sv
rtl/detection_argmax_box_decode.sv
dv/testbench.sv
